// ===== hw/rtl/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types, register indexes and the saturating add for the pixel
// binning block.
// ----------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

  localparam int PIX_W   = 16;
  localparam int CFG_DW  = 13;
  localparam int CFG_IW  = 2;
  localparam int LOG2_W  = 2;

  typedef logic [PIX_W-1:0] pixel_t;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_BIN_X_LOG2  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BIN_Y_LOG2  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH = 2'd2;

  // binning factor codes (log2)
  localparam logic [LOG2_W-1:0] LOG2_MAX = 2'd2;

  // reset values of the registers
  localparam logic [LOG2_W-1:0] BIN_LOG2_RST    = 2'd1;
  localparam logic [CFG_DW-1:0] IMAGE_WIDTH_RST = 13'd1024;

  // saturating add of two unsigned pixels
  function automatic pixel_t sat_add(input pixel_t a, input pixel_t b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W] ? {PIX_W{1'b1}} : s[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pbs_if.sv =====
// ----------------------------------------------------------------------------
// pbs_in_if / pbs_out_if
// Valid/ready stream channels for source pixels and binned pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbs_in_if
  import pbs_pkg::*;
;
  logic   valid;
  logic   ready;
  pixel_t pixel_value;
  logic   first_of_frame;

  modport source (output valid, output pixel_value, output first_of_frame, input ready);
  modport sink   (input valid, input pixel_value, input first_of_frame, output ready);
endinterface

interface pbs_out_if
  import pbs_pkg::*;
;
  logic   valid;
  logic   ready;
  pixel_t binned_value;
  logic   row_end;

  modport source (output valid, output binned_value, output row_end, input ready);
  modport sink   (input valid, input binned_value, input row_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pixel_binning_saturating_sum_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_binning_saturating_sum_unit
// Bins a raster pixel stream by 1, 2 or 4 in each direction with
// saturating sums, keeping per-column partial sums in a line buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one source pixel per word in raster order; first_of_frame
//   on a word restarts the column and row counters. out_ch gives one
//   binned pixel per complete bin, row_end on the last one of an output row.
//   cfg_we/cfg_index/cfg_wdata write bin_x_log2 (0), bin_y_log2 (1) and
//   image_width (2); write them only while the block is idle.
// Timing:
//   one word accepted per cycle while the back stage is not stalled. The
//   pixel that completes a bin is registered into the back stage together
//   with its line buffer read, and the final add is registered into the
//   output register. The read-modify-write of the line buffer is covered by
//   forwarding, so even a one-column image runs at full rate.
// Reset:
//   counters and running sum clear, registers return to 2x2 binning at
//   width 1024. The line buffer is not cleared; each entry is written by the
//   first row of a group before it is read.
// Stall:
//   while out_ch is stalled with a result waiting, words keep being accepted
//   until one completes a bin of the last row; that word waits in the back
//   stage and holds in_ch.ready low until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_binning_saturating_sum_unit
  import pbs_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pbs_in_if.sink                 in_ch,
  pbs_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > CFG_DW) ? WW : CFG_DW;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);

  typedef struct packed {
    logic          emit;
    logic          rp0;
    logic          row_end;
    logic [AW-1:0] oc;
    pixel_t        hs;
  } s1_t;

  // configuration registers
  logic [LOG2_W-1:0] bin_x_log2_r, bin_y_log2_r;
  logic [CFG_DW-1:0] image_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_x_log2_r  <= BIN_LOG2_RST;
      bin_y_log2_r  <= BIN_LOG2_RST;
      image_width_r <= IMAGE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIN_X_LOG2:  bin_x_log2_r  <= cfg_wdata[LOG2_W-1:0];
        CFG_BIN_Y_LOG2:  bin_y_log2_r  <= cfg_wdata[LOG2_W-1:0];
        CFG_IMAGE_WIDTH: image_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective factors and width
  logic [LOG2_W-1:0] lx, ly;
  logic [AW-1:0]     xmask;
  logic [1:0]        ymask;
  logic [EW-1:0]     w_e;
  logic [WW-1:0]     w, w_trunc, ow_m1;

  always_comb begin
    lx = (bin_x_log2_r > LOG2_MAX) ? LOG2_MAX : bin_x_log2_r;
    ly = (bin_y_log2_r > LOG2_MAX) ? LOG2_MAX : bin_y_log2_r;
    xmask = AW'((4'b1 << lx) - 4'b1);
    ymask = 2'((4'b1 << ly) - 4'b1);
    w_e = EW'(image_width_r);
    if (w_e == '0) begin
      w_e = EW'(1);
    end else if (w_e > MAX_W_E) begin
      w_e = MAX_W_E;
    end
    w       = w_e[WW-1:0];
    w_trunc = w & ~WW'(xmask);
    ow_m1   = (w >> lx) - WW'(1);
  end

  // control state
  logic [AW-1:0] col_r, col_nxt;
  logic [1:0]    row_phase_r, row_phase_nxt;
  pixel_t        hsum_r, hsum_nxt;

  logic s1_valid_r;
  s1_t  s1_r, s1_nxt;
  logic out_valid_r;
  pixel_t out_value_r;
  logic out_row_end_r;

  logic out_free, s1_adv, in_ready, accept;
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = !s1_r.emit || out_free;
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // front stage: counters, horizontal sum, line buffer read
  logic [AW-1:0] c;
  logic [1:0]    rp;
  pixel_t        hprev, hs;
  logic          in_range, hpos_last, take, last_col, rd_en;

  always_comb begin
    c     = in_ch.first_of_frame ? '0 : col_r;
    rp    = in_ch.first_of_frame ? 2'd0 : (row_phase_r & ymask);
    hprev = in_ch.first_of_frame ? '0 : hsum_r;
    in_range  = WW'(c) < w_trunc;
    hpos_last = (c & xmask) == xmask;
    hs = ((c & xmask) == '0) ? in_ch.pixel_value : sat_add(hprev, in_ch.pixel_value);
    take     = in_range && hpos_last;
    last_col = (WW'(c) + WW'(1)) >= w;

    s1_nxt.oc      = AW'(c >> lx);
    s1_nxt.hs      = hs;
    s1_nxt.rp0     = (rp == 2'd0);
    s1_nxt.emit    = (rp == ymask);
    s1_nxt.row_end = (WW'(s1_nxt.oc) == ow_m1);
    rd_en = accept && take && !s1_nxt.rp0;

    hsum_nxt      = in_range ? hs : hprev;
    col_nxt       = last_col ? '0 : AW'(c + AW'(1));
    row_phase_nxt = last_col ? ((rp + 2'd1) & ymask) : rp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_phase_r <= '0;
      hsum_r      <= '0;
    end else if (accept) begin
      col_r       <= col_nxt;
      row_phase_r <= row_phase_nxt;
      hsum_r      <= hsum_nxt;
    end
  end

  // line buffer
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  pixel_t        ram_wdata, ram_rdata;

  pbs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (s1_nxt.oc),
    .rdata (ram_rdata)
  );

  // back stage: vertical add, write back or emit
  logic   fwd_hit_r;
  pixel_t fwd_data_r;
  pixel_t base, v;

  always_comb begin
    base = fwd_hit_r ? fwd_data_r : ram_rdata;
    v    = s1_r.rp0 ? s1_r.hs : sat_add(base, s1_r.hs);
  end

  assign ram_we    = s1_valid_r && !s1_r.emit;
  assign ram_waddr = s1_r.oc;
  assign ram_wdata = v;

  // stage register and forwarding of a write that races the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= take;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (rd_en) begin
        fwd_hit_r <= ram_we && (ram_waddr == s1_nxt.oc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (rd_en) begin
      fwd_data_r <= v;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_r.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_r.emit && out_free) begin
      out_value_r   <= v;
      out_row_end_r <= s1_r.row_end;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.binned_value = out_value_r;
  assign out_ch.row_end      = out_row_end_r;

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_ready)
    else $error("word accepted while back stage is stalled");

  a_no_write_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (s1_valid_r && !s1_r.emit))
    else $error("line buffer written by an emitting bin");

  a_forward_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && ram_we && (ram_waddr == s1_nxt.oc)) |=> fwd_hit_r)
    else $error("racing line buffer write not forwarded");

  a_emit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.emit && out_free) |=> (out_valid_r && !s1_valid_r || out_valid_r))
    else $error("emitted bin did not reach the output register");

endmodule

`default_nettype wire

// ===== hw/rtl/pbs_ram.sv =====
// ----------------------------------------------------------------------------
// pbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write, held when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== verif/pixel_binning_saturating_sum_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_binning_saturating_sum_unit_tb
// Self-checking bench for the saturating pixel binning block.
// A scoreboard class keeps its own model of the counters, the running
// horizontal sum and the per-column line buffer, and turns each accepted
// source pixel that completes a bin into the binned word it should produce. Directed frames hit
// the register corner cases, then random frames run over many bin settings
// and widths with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module pixel_binning_saturating_sum_unit_tb;
  import pbs_pkg::*;

  localparam int          LINE_DEPTH   = 4096;
  localparam int          SETTLE       = 6;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          RANDOM_ITEMS = 1080;
  localparam int          WIDE_PIXELS  = 64;
  localparam longint      CYCLE_LIMIT  = 1000000;
  // index that maps to no register; writes to it must be ignored
  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    pixel_t value;
    logic   row_end;
  } binned_word_t;

  // expected binned words from a private model of the binning datapath
  class binning_scoreboard;
    logic [LOG2_W-1:0] bx_code;
    logic [LOG2_W-1:0] by_code;
    logic [CFG_DW-1:0] width_reg;
    int unsigned       col_pos;
    int unsigned       row_phase;
    pixel_t            hsum;
    pixel_t            line_sums [LINE_DEPTH];
    binned_word_t      expected_bins [$];
    int                errors;
    int                checked;

    function new();
      bx_code   = BIN_LOG2_RST;
      by_code   = BIN_LOG2_RST;
      width_reg = IMAGE_WIDTH_RST;
      col_pos   = 0;
      row_phase = 0;
      hsum      = '0;
      errors    = 0;
      checked   = 0;
      foreach (line_sums[i]) line_sums[i] = '0;
    endfunction

    function pixel_t clamp_sum(pixel_t a, pixel_t b);
      logic [PIX_W:0] s;
      s = a + b;
      if (s > {1'b0, {PIX_W{1'b1}}}) return {PIX_W{1'b1}};
      return s[PIX_W-1:0];
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        CFG_BIN_X_LOG2:  bx_code = value[LOG2_W-1:0];
        CFG_BIN_Y_LOG2:  by_code = value[LOG2_W-1:0];
        CFG_IMAGE_WIDTH: width_reg = value;
        default: ;
      endcase
    endfunction

    // one accepted source pixel; queues a binned word when a bin completes
    function void note_pixel(pixel_t pix, logic first);
      int unsigned  lx, ly, bx, by, w, ow, col, rp, hpos, oc;
      pixel_t       hs, v;
      binned_word_t word;
      lx = (bx_code > LOG2_MAX) ? LOG2_MAX : bx_code;
      ly = (by_code > LOG2_MAX) ? LOG2_MAX : by_code;
      bx = 1 << lx;
      by = 1 << ly;
      w  = width_reg;
      if (w == 0) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      ow = w >> lx;
      if (first) begin
        col_pos   = 0;
        row_phase = 0;
        hsum      = '0;
      end
      col = col_pos;
      rp  = row_phase & (by - 1);
      // columns past the last whole horizontal bin are dropped
      if (col < ow * bx) begin
        hpos = col & (bx - 1);
        hs   = (hpos == 0) ? pix : clamp_sum(hsum, pix);
        hsum = hs;
        if (hpos == bx - 1) begin
          oc = (col >> lx) % LINE_DEPTH;
          v  = (rp == 0) ? hs : clamp_sum(line_sums[oc], hs);
          if (rp == by - 1) begin
            word.value   = v;
            word.row_end = ((col >> lx) == ow - 1);
            expected_bins.push_back(word);
          end else begin
            line_sums[oc] = v;
          end
        end
      end
      // row wrap, also when the width shrank under the counter
      if (col + 1 >= w) begin
        col_pos   = 0;
        row_phase = (rp + 1) & (by - 1);
      end else begin
        col_pos   = col + 1;
        row_phase = rp;
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_binned(pixel_t value, logic row_end);
      binned_word_t exp_word;
      checked++;
      if (expected_bins.size() == 0) begin
        report_mismatch($sformatf("unexpected binned word value=%h row_end=%b",
                                  value, row_end));
      end else begin
        exp_word = expected_bins.pop_front();
        if (value !== exp_word.value)
          report_mismatch($sformatf("word %0d binned_value got %h want %h",
                                    checked, value, exp_word.value));
        if (row_end !== exp_word.row_end)
          report_mismatch($sformatf("word %0d row_end got %b want %b",
                                    checked, row_end, exp_word.row_end));
      end
    endtask

    task check_leftover();
      if (expected_bins.size() != 0)
        report_mismatch($sformatf("%0d binned words never arrived",
                                  expected_bins.size()));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              quiet;
  longint            cycle_count = 0;
  int                pixels_sent;
  int                settings_applied;
  binning_scoreboard sb;

  pbs_in_if  in_ch ();
  pbs_out_if out_ch ();

  pixel_binning_saturating_sum_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_binned(out_ch.binned_value, out_ch.row_end);
  end

  // output stall generator
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  function automatic pixel_t draw_pixel();
    if ($urandom_range(0, 3) == 0) return pixel_t'($urandom_range(16'hC000, 16'hFFFF));
    return pixel_t'($urandom_range(0, 16'hFFFF));
  endfunction

  // one source word, after a random gap
  task send_pixel(pixel_t pix, logic first);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pixel_value    <= pix;
    in_ch.first_of_frame <= first;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(pix, first);
    pixels_sent++;
  endtask

  // hold the input until every expected word is out, then let the pipe settle
  task wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // log2 registers get random upper bits, which the block must ignore
  task apply_setting(logic [LOG2_W-1:0] bx, logic [LOG2_W-1:0] by,
                     logic [CFG_DW-1:0] width);
    logic [CFG_DW-1:0] junk;
    wait_drained();
    junk = CFG_DW'($urandom) & ~CFG_DW'(3);
    write_reg(CFG_BIN_X_LOG2, {junk[CFG_DW-1:LOG2_W], bx});
    junk = CFG_DW'($urandom) & ~CFG_DW'(3);
    write_reg(CFG_BIN_Y_LOG2, {junk[CFG_DW-1:LOG2_W], by});
    write_reg(CFG_IMAGE_WIDTH, width);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // raster frame with occasional stray frame marks and mid-frame pauses
  task send_frame(int pixels);
    logic first;
    for (int i = 0; i < pixels; i++) begin
      first = (i == 0);
      if (i > 0 && $urandom_range(0, 49) == 0) first = 1'b1;
      if ($urandom_range(0, 299) == 0) wait_drained();
      send_pixel(draw_pixel(), first);
    end
  endtask

  initial begin
    int random_sent;
    int w;
    int byf;
    int rows;
    int frame_len;
    logic [LOG2_W-1:0] bx, by;

    sb = new();
    pixels_sent           = 0;
    settings_applied      = 0;
    quiet                <= 1'b1;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_BIN_X_LOG2;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.pixel_value    <= '0;
    in_ch.first_of_frame <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting, 2x2 over 1024 columns: a partial first row emits nothing
    for (int i = 0; i < 16; i++) send_pixel(draw_pixel(), i == 0);

    // reset bin factors over a narrow width: two rows give four words
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 13'd8);
    cfg_we <= 1'b0;
    for (int i = 0; i < 16; i++) send_pixel(draw_pixel(), i == 0);

    quiet <= 1'b0;
    // write to the spare index is ignored
    wait_drained();
    write_reg(CFG_SPARE, {CFG_DW{1'b1}});
    cfg_we <= 1'b0;

    // width zero acts as one, pass-through
    apply_setting(2'd0, 2'd0, 13'd0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);

    // factor code 3 saturates to 4; sum hits the clamp; last column dropped
    apply_setting(2'd3, 2'd0, 13'd5);
    for (int i = 0; i < 4; i++) send_pixel(16'h4000, i == 0);
    send_pixel(16'hFFFF, 1'b0);

    // 2x4 block summing to exactly full scale
    apply_setting(2'd1, 2'd3, 13'd2);
    send_pixel(16'h1FFF, 1'b1);
    for (int i = 0; i < 7; i++) send_pixel(16'h2000, 1'b0);

    // width shrinks under the column counter in the middle of a row
    apply_setting(2'd0, 2'd1, 13'd4);
    for (int i = 0; i < 3; i++) send_pixel(draw_pixel(), i == 0);
    apply_setting(2'd0, 2'd1, 13'd2);
    send_pixel(draw_pixel(), 1'b0);
    send_pixel(draw_pixel(), 1'b0);
    send_pixel(draw_pixel(), 1'b0);

    // vertical factor drops from 4 to 2 with three rows of the bin done
    apply_setting(2'd0, 2'd2, 13'd2);
    for (int i = 0; i < 6; i++) send_pixel(draw_pixel(), i == 0);
    apply_setting(2'd0, 2'd1, 13'd2);
    send_pixel(draw_pixel(), 1'b0);
    send_pixel(draw_pixel(), 1'b0);

    // width above the line buffer clamps to its depth; start of a long row
    apply_setting(2'd2, 2'd0, {CFG_DW{1'b1}});
    quiet <= 1'b1;
    for (int i = 0; i < WIDE_PIXELS; i++) send_pixel(draw_pixel(), i == 0);

    // random settings, mostly narrow images
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      bx = LOG2_W'($urandom_range(0, 3));
      by = LOG2_W'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1:    w = $urandom_range(25, 80);
        2:       w = 4 * $urandom_range(1, 8);
        default: w = $urandom_range(1, 24);
      endcase
      apply_setting(bx, by, CFG_DW'(w));
      quiet <= ($urandom_range(0, 3) == 0);
      byf = 1 << ((by > LOG2_MAX) ? LOG2_MAX : by);
      repeat ($urandom_range(1, 3)) begin
        if (random_sent >= RANDOM_ITEMS) break;
        rows      = $urandom_range(1, 3 * byf);
        frame_len = rows * w;
        // some frames are cut short
        if ($urandom_range(0, 9) == 0) frame_len = $urandom_range(1, frame_len);
        // keep to the item budget
        if (frame_len > RANDOM_ITEMS - random_sent) frame_len = RANDOM_ITEMS - random_sent;
        send_frame(frame_len);
        random_sent += frame_len;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_leftover();

    $display("sent %0d source pixels over %0d bin/width settings, checked %0d binned words",
             pixels_sent, settings_applied, sb.checked);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pbs_pkg.sv
hw/rtl/pbs_if.sv
hw/rtl/pbs_ram.sv
hw/rtl/pixel_binning_saturating_sum_unit.sv
verif/pixel_binning_saturating_sum_unit_tb.sv
